// ===== rtl/core/u2d_pkg.sv =====
package u2d_pkg;

	// Fixed field widths
	localparam int VAL_W    = 64;
	localparam int DIG_MAX  = 20;
	localparam int BCD_W    = 4 * DIG_MAX;
	localparam int CNT_W    = 5;
	localparam int BIT_W    = $clog2(VAL_W);
	localparam int CHAR_W   = 6;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_EMIT
	} state_t;

	// Commands to the shared shift/add unit
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_DABBLE,
		OP_SHIFT_DIGIT
	} op_t;

	typedef struct packed {
		op_t op;
	} u2d_cmd_t;

	typedef struct packed {
		logic [3:0] top_digit;
		logic       top_zero;
	} u2d_stat_t;

endpackage

// ===== rtl/core/u2d_bcd_unit.sv =====
module u2d_bcd_unit
	import u2d_pkg::*;
(
	input  logic             clk,
	input  logic [VAL_W-1:0] value,
	input  u2d_cmd_t         cmd,
	output u2d_stat_t        stat
);

	logic [VAL_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// Add three to every digit of five or more before the next shift
	always_comb begin
		for (int i = 0; i < DIG_MAX; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Load, shift one binary bit in, or drop the top digit
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				bin_q <= value;
				bcd_q <= '0;
			end
			OP_DABBLE: begin
				bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
				bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			end
			OP_SHIFT_DIGIT: begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign stat.top_digit = bcd_q[BCD_W-1 -: 4];
	assign stat.top_zero  = (bcd_q[BCD_W-1 -: 4] == 4'd0);

endmodule

// ===== rtl/core/u2d_ctrl.sv =====
module u2d_ctrl
	import u2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] digit_char,
	output logic [CNT_W-1:0]  position,
	output logic [CNT_W-1:0]  digit_count,
	output logic              last,
	input  u2d_stat_t         stat,
	output u2d_cmd_t          cmd
);

	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VAL_W - 1);
	localparam logic [CNT_W-1:0] DIG_FULL = CNT_W'(DIG_MAX);

	state_t           state_q, state_d;
	logic [BIT_W-1:0] bit_q;
	logic [CNT_W-1:0] digits_q;
	logic [CNT_W-1:0] pos_q;
	logic             out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic [CNT_W-1:0] position_q;
	logic [CNT_W-1:0] count_q;
	logic             last_q;

	logic in_take;
	logic trim_shift;
	logic emit_load;
	logic emit_last;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (pos_q == digits_q - CNT_W'(1));
	assign in_stall  = (state_q != ST_IDLE);

	// Next state and unit command
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_HOLD;
		in_take    = 1'b0;
		trim_shift = 1'b0;
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_take = 1'b1;
					cmd.op  = OP_LOAD;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.op = OP_DABBLE;
				if (bit_q == BIT_LAST) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (stat.top_zero && digits_q != CNT_W'(1)) begin
					trim_shift = 1'b1;
					cmd.op     = OP_SHIFT_DIGIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_load = 1'b1;
					cmd.op    = OP_SHIFT_DIGIT;
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance bit, digit and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q    <= '0;
			digits_q <= DIG_FULL;
			pos_q    <= '0;
		end else begin
			if (in_take) begin
				bit_q    <= '0;
				digits_q <= DIG_FULL;
				pos_q    <= '0;
			end else begin
				if (state_q == ST_CONV) begin
					bit_q <= bit_q + BIT_W'(1);
				end
				if (trim_shift) begin
					digits_q <= digits_q - CNT_W'(1);
				end
				if (emit_load) begin
					pos_q <= pos_q + CNT_W'(1);
				end
			end
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			char_q     <= {2'b11, stat.top_digit};
			position_q <= pos_q;
			count_q    <= digits_q;
			last_q     <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_char  = char_q;
	assign position    = position_q;
	assign digit_count = count_q;
	assign last        = last_q;

endmodule

// ===== rtl/core/uint64_to_decimal_ascii_top.sv =====
// Conversion: a value is converted by 64 shift-and-adjust steps, then leading zero digits are
// dropped for an n-digit result before the first digit beat is sent.
// Throughput: one digit beat per cycle without stall; the single shared BCD shift/add unit
// works on one item at a time. The input stalls while an item is in work.
// Reset (arst_n, asynchronous, active low) clears the sequencer and output valid.
module uint64_to_decimal_ascii_top
	import u2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] digit_char,
	output logic [CNT_W-1:0]  position,
	output logic [CNT_W-1:0]  digit_count,
	output logic              last
);

	u2d_cmd_t  cmd;
	u2d_stat_t stat;

	u2d_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digit_char  (digit_char),
		.position    (position),
		.digit_count (digit_count),
		.last        (last),
		.stat        (stat),
		.cmd         (cmd)
	);

	u2d_bcd_unit u_bcd (
		.clk   (clk),
		.value (value),
		.cmd   (cmd),
		.stat  (stat)
	);

endmodule

// ===== rtl/core/u2d_checker.sv =====
module u2d_checker
	import u2d_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] digit_char,
	input logic [CNT_W-1:0]  position,
	input logic [CNT_W-1:0]  digit_count,
	input logic              last
);

	// An accepted beat keeps the input busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(position))
		else $error("stalled output beat changed");

	// Character is a decimal digit
	a_digit_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9)
		else $error("character is not a decimal digit");

	// Position lies inside the run and last marks its end
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position < digit_count && digit_count != 5'd0
			&& digit_count <= 5'd20
			&& last == (position == digit_count - 5'd1))
		else $error("position, count or last inconsistent");

	// The next beat of a run follows the previous position
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last ##1 out_valid |->
			position == $past(position) + 5'd1)
		else $error("digit position skipped");

endmodule

bind uint64_to_decimal_ascii_top u2d_checker u_u2d_checker (.*);
